[rtl/mlsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsm_pkg
// shared types and constants of the multi-list slot manager
// ----------------------------------------------------------------------------
package mlsm_pkg;

    localparam int CMD_W    = 2;
    localparam int LIST_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

    localparam logic [SYM_W-1:0] REMOVED_SYMBOL = 8'h2D;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_WR_NEW,
        ST_RD_HEAD,
        ST_WR_HEAD,
        ST_RD_SLOT,
        ST_LINK,
        ST_RD_NX,
        ST_WR_NX,
        ST_RD_PV,
        ST_WR_PV,
        ST_CLR,
        ST_RD_OUT,
        ST_OUT
    } mlsm_state_t;

endpackage

[rtl/multi_list_slot_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_list_slot_manager
// pool of slots shared by several doubly linked lists, kept in one entry ram
// ----------------------------------------------------------------------------
// latency from accept to result depends on the command: a query, or a remove
// of an unused slot, only reads the slot; a remove of a used slot relinks its
// neighbours; an add scans free slots, one aligned group of 8 slots per cycle
// one item at a time; the entry ram with its single read port sets the pace
// reset clears list heads, search pointer, used marks and entry valid bits at
// once, so the block takes an item in the first cycle after reset
module multi_list_slot_manager #(
    parameter int SLOTS = 64,
    parameter int LISTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], list_id[3:2], slot[9:4], symbol_in[17:10], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], slot_out[7:2], head_out[13:8], next_out[19:14],
    // prev_out[25:20], symbol_out[33:26], in_use[34], zero fill
    output logic [39:0] m_axis_tdata
);

    localparam int SW = $clog2(SLOTS);
    localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int NW = (SLOTS + 7) / 8;
    localparam int WW = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW = $clog2(NW + 1);

    typedef struct packed {
        logic [mlsm_pkg::SYM_W-1:0] sym;
        logic [SW-1:0]              nxt;
        logic [SW-1:0]              prv;
    } entry_t;

    mlsm_pkg::mlsm_state_t state_reg, state_next;

    logic [mlsm_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [LW-1:0]                 list_reg, list_next;
    logic [SW-1:0]                 slot_reg, slot_next;
    logic [mlsm_pkg::SYM_W-1:0]    sym_reg, sym_next;
    logic [mlsm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [SW-1:0]                 head_reg, head_next;
    logic [SW-1:0]                 nx_reg, nx_next;
    logic [SW-1:0]                 pv_reg, pv_next;
    logic [WW-1:0]                 wptr_reg, wptr_next;
    logic [CW-1:0]                 step_reg, step_next;
    logic [SW-1:0]                 sp_reg, sp_next;
    logic [SLOTS-1:0]              used_reg, used_next;
    logic [SW-1:0]                 heads_reg [LISTS];
    logic [SW-1:0]                 heads_next [LISTS];

    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;

    entry_t           mem_ram [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    entry_t           rdata_reg;
    logic             rd_valid_reg;
    entry_t           rd_entry;
    logic             mem_we;
    logic [SW-1:0]    mem_wa;
    entry_t           mem_wd;
    logic             mem_re;
    logic [SW-1:0]    mem_ra;

    logic [SW-1:0] slot_mod [64];
    logic [LW-1:0] list_mod [4];
    logic [NW*8-1:0] free_vec;
    logic [7:0]      word_bits, word_mask, word_hit;
    logic [2:0]      hit_pos;
    logic            search_hit;
    logic [SW-1:0]   found_slot;
    logic [SW-1:0]   head_cur;
    logic [2:0]      sp_off;
    logic            out_load;

    for (genvar g = 0; g < 64; g++)
    begin : g_slot_mod
        assign slot_mod[g] = SW'(g % SLOTS);
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_list_mod
        assign list_mod[g] = LW'(g % LISTS);
    end

    for (genvar i = 0; i < NW * 8; i++)
    begin : g_free
        if (i > 0 && i < SLOTS)
        begin : g_slot
            assign free_vec[i] = ~used_reg[i];
        end
        else
        begin : g_pad
            assign free_vec[i] = 1'b0;
        end
    end

    // free-slot scan over one aligned group of 8
    assign sp_off    = 3'(sp_reg);
    assign word_bits = free_vec[{wptr_reg, 3'b000} +: 8];
    assign word_hit  = word_bits & word_mask;
    assign search_hit = |word_hit;
    assign found_slot = SW'({wptr_reg, hit_pos});

    always_comb
    begin
        if (step_reg == CW'(0))
        begin
            word_mask = 8'hFF << sp_off;
        end
        else if (step_reg == CW'(NW))
        begin
            word_mask = ~(8'hFF << sp_off);
        end
        else
        begin
            word_mask = 8'hFF;
        end
    end

    always_comb
    begin
        hit_pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (word_hit[i])
            begin
                hit_pos = 3'(i);
            end
        end
    end

    assign head_cur = heads_reg[list_reg];
    assign rd_entry = rd_valid_reg ? rdata_reg : '0;
    assign out_load = (state_reg == mlsm_pkg::ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == mlsm_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlsm_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = mlsm_pkg::ST_START;
                end
            end
            mlsm_pkg::ST_START:
            begin
                if (cmd_reg == mlsm_pkg::CMD_ADD)
                begin
                    state_next = mlsm_pkg::ST_SEARCH;
                end
                else if (cmd_reg == mlsm_pkg::CMD_REMOVE && used_reg[slot_reg])
                begin
                    state_next = mlsm_pkg::ST_RD_SLOT;
                end
                else
                begin
                    state_next = mlsm_pkg::ST_RD_OUT;
                end
            end
            mlsm_pkg::ST_SEARCH:
            begin
                if (search_hit)
                begin
                    state_next = mlsm_pkg::ST_WR_NEW;
                end
                else if (step_reg == CW'(NW))
                begin
                    state_next = mlsm_pkg::ST_RD_OUT;
                end
            end
            mlsm_pkg::ST_WR_NEW:
            begin
                if (head_cur != '0)
                begin
                    state_next = mlsm_pkg::ST_RD_HEAD;
                end
                else
                begin
                    state_next = mlsm_pkg::ST_RD_OUT;
                end
            end
            mlsm_pkg::ST_RD_HEAD: state_next = mlsm_pkg::ST_WR_HEAD;
            mlsm_pkg::ST_WR_HEAD: state_next = mlsm_pkg::ST_RD_OUT;
            mlsm_pkg::ST_RD_SLOT: state_next = mlsm_pkg::ST_LINK;
            mlsm_pkg::ST_LINK:
            begin
                if (rd_entry.nxt != '0)
                begin
                    state_next = mlsm_pkg::ST_RD_NX;
                end
                else if (rd_entry.prv != '0)
                begin
                    state_next = mlsm_pkg::ST_RD_PV;
                end
                else
                begin
                    state_next = mlsm_pkg::ST_CLR;
                end
            end
            mlsm_pkg::ST_RD_NX: state_next = mlsm_pkg::ST_WR_NX;
            mlsm_pkg::ST_WR_NX:
            begin
                if (pv_reg != '0)
                begin
                    state_next = mlsm_pkg::ST_RD_PV;
                end
                else
                begin
                    state_next = mlsm_pkg::ST_CLR;
                end
            end
            mlsm_pkg::ST_RD_PV: state_next = mlsm_pkg::ST_WR_PV;
            mlsm_pkg::ST_WR_PV: state_next = mlsm_pkg::ST_CLR;
            mlsm_pkg::ST_CLR:   state_next = mlsm_pkg::ST_RD_OUT;
            mlsm_pkg::ST_RD_OUT: state_next = mlsm_pkg::ST_OUT;
            mlsm_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = mlsm_pkg::ST_IDLE;
                end
            end
            default: state_next = mlsm_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        cmd_next    = cmd_reg;
        list_next   = list_reg;
        slot_next   = slot_reg;
        sym_next    = sym_reg;
        status_next = status_reg;
        head_next   = head_reg;
        nx_next     = nx_reg;
        pv_next     = pv_reg;
        wptr_next   = wptr_reg;
        step_next   = step_reg;
        sp_next     = sp_reg;
        used_next   = used_reg;
        heads_next  = heads_reg;
        mem_we      = 1'b0;
        mem_wa      = slot_reg;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = slot_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mlsm_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next  = s_axis_tdata[1:0];
                    list_next = list_mod[s_axis_tdata[3:2]];
                    slot_next = slot_mod[s_axis_tdata[9:4]];
                    sym_next  = s_axis_tdata[17:10];
                end
            end
            mlsm_pkg::ST_START:
            begin
                step_next   = '0;
                wptr_next   = WW'(sp_reg >> 3);
                status_next = mlsm_pkg::STATUS_OK;
                if (cmd_reg == mlsm_pkg::CMD_REMOVE && !used_reg[slot_reg])
                begin
                    status_next = mlsm_pkg::STATUS_NOT_USED;
                end
            end
            mlsm_pkg::ST_SEARCH:
            begin
                if (search_hit)
                begin
                    slot_next = found_slot;
                end
                else if (step_reg == CW'(NW))
                begin
                    status_next = mlsm_pkg::STATUS_FULL;
                    slot_next   = '0;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                    if (wptr_reg == WW'(NW - 1))
                    begin
                        wptr_next = '0;
                    end
                    else
                    begin
                        wptr_next = wptr_reg + WW'(1);
                    end
                end
            end
            mlsm_pkg::ST_WR_NEW:
            begin
                mem_we     = 1'b1;
                mem_wa     = slot_reg;
                mem_wd.sym = sym_reg;
                mem_wd.nxt = head_cur;
                mem_wd.prv = '0;
                used_next[slot_reg]  = 1'b1;
                sp_next              = slot_reg;
                head_next            = head_cur;
                heads_next[list_reg] = slot_reg;
            end
            mlsm_pkg::ST_RD_HEAD:
            begin
                mem_re = 1'b1;
                mem_ra = head_reg;
            end
            mlsm_pkg::ST_WR_HEAD:
            begin
                mem_we     = 1'b1;
                mem_wa     = head_reg;
                mem_wd.sym = rd_entry.sym;
                mem_wd.nxt = rd_entry.nxt;
                mem_wd.prv = slot_reg;
            end
            mlsm_pkg::ST_RD_SLOT:
            begin
                mem_re = 1'b1;
                mem_ra = slot_reg;
            end
            mlsm_pkg::ST_LINK:
            begin
                nx_next = rd_entry.nxt;
                pv_next = rd_entry.prv;
            end
            mlsm_pkg::ST_RD_NX:
            begin
                mem_re = 1'b1;
                mem_ra = nx_reg;
            end
            mlsm_pkg::ST_WR_NX:
            begin
                mem_we     = 1'b1;
                mem_wa     = nx_reg;
                mem_wd.sym = rd_entry.sym;
                mem_wd.nxt = rd_entry.nxt;
                mem_wd.prv = pv_reg;
            end
            mlsm_pkg::ST_RD_PV:
            begin
                mem_re = 1'b1;
                mem_ra = pv_reg;
            end
            mlsm_pkg::ST_WR_PV:
            begin
                mem_we     = 1'b1;
                mem_wa     = pv_reg;
                mem_wd.sym = rd_entry.sym;
                mem_wd.nxt = nx_reg;
                mem_wd.prv = rd_entry.prv;
            end
            mlsm_pkg::ST_CLR:
            begin
                mem_we     = 1'b1;
                mem_wa     = slot_reg;
                mem_wd.sym = mlsm_pkg::REMOVED_SYMBOL;
                mem_wd.nxt = '0;
                mem_wd.prv = '0;
                used_next[slot_reg] = 1'b0;
                if (head_cur == slot_reg)
                begin
                    heads_next[list_reg] = nx_reg;
                end
            end
            mlsm_pkg::ST_RD_OUT:
            begin
                mem_re = 1'b1;
                mem_ra = slot_reg;
            end
            mlsm_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0,
                                      used_reg[slot_reg],
                                      rd_entry.sym,
                                      mlsm_pkg::SLOT_W'(rd_entry.prv),
                                      mlsm_pkg::SLOT_W'(rd_entry.nxt),
                                      mlsm_pkg::SLOT_W'(head_cur),
                                      mlsm_pkg::SLOT_W'(slot_reg),
                                      status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // entry ram, one write and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_ram[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_ram[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_valid_reg <= valid_reg[mem_ra];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlsm_pkg::ST_IDLE;
            sp_reg        <= '0;
            used_reg      <= '0;
            heads_reg     <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            used_reg      <= used_next;
            heads_reg     <= heads_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        list_reg     <= list_next;
        slot_reg     <= slot_next;
        sym_reg      <= sym_next;
        status_reg   <= status_next;
        head_reg     <= head_next;
        nx_reg       <= nx_next;
        pv_reg       <= pv_next;
        wptr_reg     <= wptr_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

endmodule

[tb/mlsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsm_checker
// watches both stream channels of the slot manager, keeps its own copy of the
// slot pool and list heads, works out the report for every accepted command
// and compares each returned report field by field against the oldest one
// ----------------------------------------------------------------------------
module mlsm_checker
    import mlsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // cmd[1:0], list_id[3:2], slot[9:4], symbol_in[17:10], zero fill
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], slot_out[7:2], head_out[13:8], next_out[19:14],
    // prev_out[25:20], symbol_out[33:26], in_use[34], zero fill
    input  logic [39:0] m_axis_tdata,
    output int          mismatch_count,
    output int          reports_pending
);

    localparam int SLOTS = 64;
    localparam int LISTS = 4;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   head;
        logic [SLOT_W-1:0]   next;
        logic [SLOT_W-1:0]   prev;
        logic [SYM_W-1:0]    symbol;
        logic                in_use;
    } slot_report_t;

    logic              slot_used   [SLOTS];
    logic [SYM_W-1:0]  slot_symbol [SLOTS];
    logic [SLOT_W-1:0] slot_next   [SLOTS];
    logic [SLOT_W-1:0] slot_prev   [SLOTS];
    logic [SLOT_W-1:0] list_head   [LISTS];
    logic [SLOT_W-1:0] search_ptr;

    slot_report_t awaited_reports [$];
    int           report_index;

    // updates the pool for one command and returns the report it produces
    function automatic slot_report_t apply_command(input logic [23:0] item);
        logic [CMD_W-1:0]    cmd;
        logic [LIST_W-1:0]   lst;
        logic [SLOT_W-1:0]   s;
        logic [SYM_W-1:0]    sym;
        logic [STATUS_W-1:0] st;
        logic [SLOT_W-1:0]   c;
        logic [SLOT_W-1:0]   hd;
        logic [SLOT_W-1:0]   nx;
        logic [SLOT_W-1:0]   pv;
        logic                found_free;
        slot_report_t        rep;
        int                  k;
        cmd = item[1:0];
        lst = item[3:2];
        s   = item[9:4];
        sym = item[17:10];
        st  = STATUS_OK;
        if (cmd == CMD_ADD)
        begin
            found_free = 1'b0;
            s = '0;
            for (k = 0; k < SLOTS; k++)
            begin
                c = search_ptr + k[SLOT_W-1:0];
                if (!found_free && c != '0 && !slot_used[c])
                begin
                    s = c;
                    found_free = 1'b1;
                end
            end
            if (found_free)
            begin
                search_ptr = s;
                hd = list_head[lst];
                slot_next[s] = hd;
                slot_prev[s] = '0;
                if (hd != '0)
                    slot_prev[hd] = s;
                list_head[lst] = s;
                slot_used[s] = 1'b1;
                slot_symbol[s] = sym;
            end
            else
                st = STATUS_FULL;
        end
        else if (cmd == CMD_REMOVE)
        begin
            if (s == '0 || !slot_used[s])
                st = STATUS_NOT_USED;
            else
            begin
                nx = slot_next[s];
                pv = slot_prev[s];
                if (nx != '0)
                    slot_prev[nx] = pv;
                if (pv != '0)
                    slot_next[pv] = nx;
                if (list_head[lst] == s)
                    list_head[lst] = nx;
                slot_next[s] = '0;
                slot_prev[s] = '0;
                slot_used[s] = 1'b0;
                slot_symbol[s] = REMOVED_SYMBOL;
            end
        end
        rep.status = st;
        rep.slot   = s;
        rep.head   = list_head[lst];
        rep.next   = slot_next[s];
        rep.prev   = slot_prev[s];
        rep.symbol = slot_symbol[s];
        rep.in_use = slot_used[s];
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("report %0d: %s expected %0h, got %0h",
                         report_index, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i]   = 1'b0;
                slot_symbol[i] = '0;
                slot_next[i]   = '0;
                slot_prev[i]   = '0;
            end
            for (int j = 0; j < LISTS; j++)
                list_head[j] = '0;
            search_ptr = '0;
            awaited_reports.delete();
            report_index = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_reports.push_back(apply_command(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("report %0d: unexpected item %h", report_index,
                                 m_axis_tdata);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("status", 8'(want.status), 8'(m_axis_tdata[1:0]));
                    check_field("slot_out", 8'(want.slot), 8'(m_axis_tdata[7:2]));
                    check_field("head_out", 8'(want.head), 8'(m_axis_tdata[13:8]));
                    check_field("next_out", 8'(want.next), 8'(m_axis_tdata[19:14]));
                    check_field("prev_out", 8'(want.prev), 8'(m_axis_tdata[25:20]));
                    check_field("symbol_out", want.symbol, m_axis_tdata[33:26]);
                    check_field("in_use", 8'(want.in_use), 8'(m_axis_tdata[34]));
                    check_field("zero fill", 8'd0, 8'(m_axis_tdata[39:35]));
                end
                report_index++;
            end
        end
        reports_pending = awaited_reports.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives add, remove and query commands into the slot manager: a directed
// opening over the corner cases, then random phases that fill, churn and drain
// the pool under varying sender gaps and receiver stalls; the checker judges
// ----------------------------------------------------------------------------
module tb_top;
    import mlsm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int SEGMENTS     = 8;
    localparam int SEGMENT_LEN  = 142;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum int { MIX_CHURN, MIX_FILL, MIX_DRAIN } op_mix_t;
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // cmd[1:0], list_id[3:2], slot[9:4], symbol_in[17:10], zero fill
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // status[1:0], slot_out[7:2], head_out[13:8], next_out[19:14],
    // prev_out[25:20], symbol_out[33:26], in_use[34], zero fill
    logic [39:0] m_axis_tdata;

    int         mismatch_count;
    int         reports_pending;
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         cycle_count = 0;

    multi_list_slot_manager dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    mlsm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .reports_pending(reports_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [23:0] pack_item(input logic [CMD_W-1:0] cmd,
                                              input logic [LIST_W-1:0] lst,
                                              input logic [SLOT_W-1:0] s,
                                              input logic [SYM_W-1:0] sym);
        return {6'b0, sym, s, lst, cmd};
    endfunction

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 62;
            IDLE_BOTH:   return $urandom_range(99) < 9;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 62;
            IDLE_BOTH:     return $urandom_range(99) < 9;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic [23:0] random_item(input op_mix_t mix);
        int               roll;
        int               add_below;
        int               remove_below;
        logic [CMD_W-1:0] cmd;
        logic [SLOT_W-1:0] s;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:
            begin
                add_below = 92;
                remove_below = 97;
            end
            MIX_DRAIN:
            begin
                add_below = 12;
                remove_below = 85;
            end
            default:
            begin
                add_below = 45;
                remove_below = 85;
            end
        endcase
        s = SLOT_W'($urandom_range(63));
        if (roll < add_below)
            cmd = CMD_ADD;
        else if (roll < remove_below)
        begin
            cmd = CMD_REMOVE;
            s = ($urandom_range(19) == 0) ? '0 : SLOT_W'($urandom_range(63, 1));
        end
        else
            cmd = $urandom_range(1) ? CMD_QUERY : CMD_SPARE;
        return pack_item(cmd, LIST_W'($urandom_range(3)), s, SYM_W'($urandom_range(255)));
    endfunction

    task automatic send_item(input logic [23:0] item);
        if (sender_gap())
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (sender_gap());
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !receiver_stall();
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int seg;
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pool, unused slots, slot zero
        send_item(pack_item(CMD_QUERY, 2'd0, 6'd0, 8'h00));
        send_item(pack_item(CMD_REMOVE, 2'd0, 6'd0, 8'hFF));
        send_item(pack_item(CMD_REMOVE, 2'd3, 6'd63, 8'h00));
        // build lists with extreme symbols
        send_item(pack_item(CMD_ADD, 2'd0, 6'd63, 8'hFF));
        send_item(pack_item(CMD_ADD, 2'd0, 6'd0, 8'h00));
        send_item(pack_item(CMD_ADD, 2'd1, 6'd21, 8'hA5));
        send_item(pack_item(CMD_ADD, 2'd3, 6'd42, 8'h5A));
        send_item(pack_item(CMD_ADD, 2'd2, 6'd0, REMOVED_SYMBOL));
        send_item(pack_item(CMD_ADD, 2'd3, 6'd0, 8'h80));
        send_item(pack_item(CMD_SPARE, 2'd0, 6'd1, 8'h00));
        // tail removal, wrong-list removal, head removal
        send_item(pack_item(CMD_REMOVE, 2'd0, 6'd1, 8'h00));
        send_item(pack_item(CMD_REMOVE, 2'd2, 6'd3, 8'h00));
        send_item(pack_item(CMD_QUERY, 2'd1, 6'd3, 8'h00));
        send_item(pack_item(CMD_REMOVE, 2'd0, 6'd2, 8'h00));
        send_item(pack_item(CMD_REMOVE, 2'd1, 6'd3, 8'h00));
        send_item(pack_item(CMD_REMOVE, 2'd3, 6'd4, 8'h00));
        send_item(pack_item(CMD_QUERY, 2'd3, 6'd6, 8'h00));
        send_item(pack_item(CMD_ADD, 2'd1, 6'd0, 8'h01));
        send_item(pack_item(CMD_SPARE, 2'd3, 6'd63, 8'h00));
        send_item(pack_item(CMD_QUERY, 2'd2, 6'd32, 8'h00));

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_mode = idle_mode_t'(seg % 4);
            if (seg == 0 || seg == 4)
                hold_req <= hold_req + 1;
            for (n = 0; n < SEGMENT_LEN; n++)
                send_item(random_item(op_mix_t'(seg % 3)));
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
